/* hdl/sslf_pkg.sv */
// ----------------------------------------------------------------------------
// sslf_pkg
// Shared types and constants of the stream session lifecycle controller.
// ----------------------------------------------------------------------------
package sslf_pkg;

   localparam int TIMER_WIDTH_DEF = 16;
   localparam int OP_WIDTH        = 4;
   localparam int CAT_WIDTH       = 2;
   localparam int CSR_IDX_WIDTH   = 2;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam int TIMEOUT_WIDTH   = 16;

   // event codes
   localparam logic [OP_WIDTH-1:0] OP_TICK        = 4'd0;
   localparam logic [OP_WIDTH-1:0] OP_START       = 4'd1;
   localparam logic [OP_WIDTH-1:0] OP_STOP        = 4'd2;
   localparam logic [OP_WIDTH-1:0] OP_PAUSE       = 4'd3;
   localparam logic [OP_WIDTH-1:0] OP_RESUME      = 4'd4;
   localparam logic [OP_WIDTH-1:0] OP_RX_STARTED  = 4'd5;
   localparam logic [OP_WIDTH-1:0] OP_RX_STOPPED  = 4'd6;
   localparam logic [OP_WIDTH-1:0] OP_RX_PAUSED   = 4'd7;
   localparam logic [OP_WIDTH-1:0] OP_RX_RESUMED  = 4'd8;
   localparam logic [OP_WIDTH-1:0] OP_FIRST_FRAME = 4'd9;
   localparam logic [OP_WIDTH-1:0] OP_RX_ERROR    = 4'd10;

   localparam logic [CAT_WIDTH-1:0] CAT_FATAL = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ALLOW_SOFT    = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_RX_BOUND      = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_START_TIMEOUT = 2'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_STOP_TIMEOUT  = 2'd3;

   localparam logic [TIMEOUT_WIDTH-1:0] START_TIMEOUT_RST = 16'd10000;
   localparam logic [TIMEOUT_WIDTH-1:0] STOP_TIMEOUT_RST  = 16'd5000;

   typedef enum logic [2:0] {
      ST_IDLE         = 3'd0,
      ST_STARTING     = 3'd1,
      ST_CONNECTED    = 3'd2,
      ST_STREAMING    = 3'd3,
      ST_PAUSED       = 3'd4,
      ST_RECONNECTING = 3'd5,
      ST_STOPPING     = 3'd6,
      ST_FAILED       = 3'd7
   } sslf_state_type;

   typedef struct packed {
      logic                     allow_soft;
      logic                     rx_bound;
      logic [TIMEOUT_WIDTH-1:0] start_timeout;
      logic [TIMEOUT_WIDTH-1:0] stop_timeout;
   } sslf_cfg_type;

   typedef struct packed {
      sslf_state_type state;
      logic           changed;
      logic           start_rx;
      logic           arm_rx;
      logic           fully_started;
      logic           stop_rx;
      logic           fully_stopped;
      logic           reconnect;
   } sslf_result_type;

endpackage

/* hdl/sslf_csr.sv */
// ----------------------------------------------------------------------------
// sslf_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module sslf_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [sslf_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [sslf_pkg::CSR_DATA_WIDTH-1:0] csr_data,
   output sslf_pkg::sslf_cfg_type              cfg
);
   import sslf_pkg::*;

   sslf_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.allow_soft    <= 1'b1;
         cfg_ff.rx_bound      <= 1'b0;
         cfg_ff.start_timeout <= START_TIMEOUT_RST;
         cfg_ff.stop_timeout  <= STOP_TIMEOUT_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_ALLOW_SOFT:    cfg_ff.allow_soft    <= csr_data[0];
            CSR_RX_BOUND:      cfg_ff.rx_bound      <= csr_data[0];
            CSR_START_TIMEOUT: cfg_ff.start_timeout <= csr_data[TIMEOUT_WIDTH-1:0];
            CSR_STOP_TIMEOUT:  cfg_ff.stop_timeout  <= csr_data[TIMEOUT_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

/* hdl/sslf_fsm.sv */
// ----------------------------------------------------------------------------
// sslf_fsm
// Session state machine with dwell timer; one event per step.
// ----------------------------------------------------------------------------
module sslf_fsm #(
   parameter int TIMER_WIDTH = sslf_pkg::TIMER_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [sslf_pkg::OP_WIDTH-1:0]  op,
   input  logic [sslf_pkg::CAT_WIDTH-1:0] error_category,
   input  sslf_pkg::sslf_cfg_type         cfg,
   output sslf_pkg::sslf_result_type      result
);
   import sslf_pkg::*;

   localparam int CMP_WIDTH = (TIMER_WIDTH > TIMEOUT_WIDTH) ? TIMER_WIDTH : TIMEOUT_WIDTH;

   sslf_state_type         state_ff, state_in;
   logic                   seen_start_ff, seen_start_in;
   logic [TIMER_WIDTH-1:0] dwell_ff, dwell_in, dwell_inc;

   logic           fatal;
   logic           tick_counted;
   logic           start_expired, stop_expired;
   sslf_state_type fatal_state;
   sslf_state_type nx_state;
   logic           changed;

   assign fatal        = (op == OP_RX_ERROR) && (error_category == CAT_FATAL);
   assign tick_counted = (op == OP_TICK) &&
                         ((state_ff == ST_STARTING) || (state_ff == ST_STOPPING));
   // saturating dwell count, as seen by this tick
   assign dwell_inc    = (&dwell_ff) ? dwell_ff : dwell_ff + 1'b1;
   assign start_expired = CMP_WIDTH'(dwell_inc) >= CMP_WIDTH'(cfg.start_timeout);
   assign stop_expired  = CMP_WIDTH'(dwell_inc) >= CMP_WIDTH'(cfg.stop_timeout);
   assign fatal_state   = cfg.allow_soft ? ST_RECONNECTING : ST_FAILED;

   // next state
   always_comb begin
      nx_state = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (op == OP_START) nx_state = ST_STARTING;
         end
         ST_STARTING: begin
            if (op == OP_RX_STARTED)                nx_state = ST_CONNECTED;
            else if (fatal)                         nx_state = fatal_state;
            else if (op == OP_STOP)                 nx_state = ST_STOPPING;
            else if (op == OP_TICK && start_expired) nx_state = ST_FAILED;
         end
         ST_CONNECTED: begin
            if (op == OP_FIRST_FRAME)                          nx_state = ST_STREAMING;
            else if (op == OP_RX_PAUSED || op == OP_PAUSE)     nx_state = ST_PAUSED;
            else if (fatal)                                    nx_state = fatal_state;
            else if (op == OP_STOP)                            nx_state = ST_STOPPING;
         end
         ST_STREAMING: begin
            if (op == OP_RX_PAUSED || op == OP_PAUSE) nx_state = ST_PAUSED;
            else if (fatal)                           nx_state = fatal_state;
            else if (op == OP_STOP)                   nx_state = ST_STOPPING;
         end
         ST_PAUSED: begin
            if (op == OP_RX_RESUMED || op == OP_RESUME) nx_state = ST_STREAMING;
            else if (fatal)                             nx_state = fatal_state;
            else if (op == OP_STOP)                     nx_state = ST_STOPPING;
         end
         ST_RECONNECTING: begin
            if (op == OP_RX_STARTED) nx_state = ST_CONNECTED;
            else if (fatal)          nx_state = fatal_state;
            else if (op == OP_STOP)  nx_state = ST_STOPPING;
            else if (op == OP_START) nx_state = ST_STARTING;
         end
         ST_STOPPING: begin
            if (op == OP_RX_STOPPED)                nx_state = ST_IDLE;
            else if (op == OP_TICK && stop_expired) nx_state = ST_IDLE;
         end
         ST_FAILED: nx_state = ST_FAILED;
      endcase
   end

   assign changed = (nx_state != state_ff);

   // entry actions
   always_comb begin
      result               = '0;
      result.state         = changed ? nx_state : state_ff;
      result.changed       = changed;
      if (changed) begin
         unique case (nx_state)
            ST_IDLE:         result.fully_stopped = seen_start_ff & cfg.rx_bound;
            ST_STARTING:     result.start_rx      = cfg.rx_bound;
            ST_CONNECTED: begin
               result.arm_rx        = cfg.rx_bound;
               result.fully_started = 1'b1;
            end
            ST_STOPPING:     result.stop_rx       = cfg.rx_bound;
            ST_RECONNECTING: result.reconnect     = 1'b1;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      seen_start_in = seen_start_ff;
      dwell_in      = dwell_ff;
      if (step) begin
         if (changed) begin
            state_in = nx_state;
            dwell_in = '0;
            if (nx_state == ST_IDLE)     seen_start_in = 1'b0;
            if (nx_state == ST_STARTING) seen_start_in = 1'b1;
         end else if (tick_counted) begin
            dwell_in = dwell_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seen_start_ff <= 1'b0;
         dwell_ff      <= '0;
      end else begin
         state_ff      <= state_in;
         seen_start_ff <= seen_start_in;
         dwell_ff      <= dwell_in;
      end
   end

`ifndef SYNTHESIS
   a_failed_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FAILED |=> state_ff == ST_FAILED)
      else $error("left failed state");
   a_dwell_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_STARTING && state_ff != ST_STOPPING) |-> dwell_ff == '0)
      else $error("dwell counter running outside timed states");
   a_no_flags: assert property (@(posedge clock) disable iff (reset)
      !result.changed |-> !(result.start_rx | result.arm_rx | result.fully_started |
                            result.stop_rx | result.fully_stopped | result.reconnect))
      else $error("entry flag without state change");
   a_idle_seen: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !seen_start_ff)
      else $error("start mark held in idle");
`endif

endmodule

/* hdl/stream_session_lifecycle_fsm_top.sv */
// ----------------------------------------------------------------------------
// stream_session_lifecycle_fsm_top
// Streaming session lifecycle controller: one event word in, one status word out.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one event word (op, error_category) per accepted handshake
//   (req_valid high, req_stall low). rsp_* returns exactly one status word per
//   event: session state, a state-changed bit and one-shot entry action flags.
//   csr_* writes the four configuration registers; write only while idle.
// Pipe: an accepted event is held in the input register and is evaluated into the
//   result register once that register is free, so the word shows from then on.
// Throughput: one event per cycle while rsp_stall is low; a single input register
//   plus the result register form the pipe, so one further event is taken while
//   a result waits under rsp_stall, after which req_stall rises.
// Reset (synchronous): state idle, dwell timer and start mark cleared, both
//   registers of the pipe empty, configuration back to its defaults.
// Stall: a stalled result word holds unchanged; the session state advances
//   only when an event moves from the input register into the result register.
// ----------------------------------------------------------------------------
module stream_session_lifecycle_fsm_top #(
   parameter int TIMER_WIDTH = sslf_pkg::TIMER_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // event channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [sslf_pkg::OP_WIDTH-1:0]       req_op,
   input  logic [sslf_pkg::CAT_WIDTH-1:0]      req_error_category,
   // status channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [2:0]                          rsp_session_state,
   output logic                                rsp_state_changed,
   output logic                                rsp_cmd_start_receiver,
   output logic                                rsp_cmd_arm_receiver,
   output logic                                rsp_note_fully_started,
   output logic                                rsp_cmd_stop_receiver,
   output logic                                rsp_note_fully_stopped,
   output logic                                rsp_note_reconnect,
   // configuration
   input  logic                                csr_wr_en,
   input  logic [sslf_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [sslf_pkg::CSR_DATA_WIDTH-1:0] csr_data
);
   import sslf_pkg::*;

   // input register
   logic                 in_valid_ff, in_valid_in;
   logic [OP_WIDTH-1:0]  op_ff;
   logic [CAT_WIDTH-1:0] cat_ff;

   // result register
   logic            out_valid_ff, out_valid_in;
   sslf_result_type out_ff;

   sslf_cfg_type    cfg;
   sslf_result_type result;
   logic            out_free;   // result register can take a new word
   logic            advance;    // event moves from input to result register
   logic            req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   // input register frees up when its word advances
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   sslf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sslf_fsm #(
      .TIMER_WIDTH (TIMER_WIDTH)
   ) u_fsm (
      .clock          (clock),
      .reset          (reset),
      .step           (advance),
      .op             (op_ff),
      .error_category (cat_ff),
      .cfg            (cfg),
      .result         (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (advance)  in_valid_in = 1'b0;
      if (req_take) in_valid_in = 1'b1;
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (out_free) out_valid_in = advance;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff  <= req_op;
         cat_ff <= req_error_category;
      end
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_valid              = out_valid_ff;
   assign rsp_session_state      = out_ff.state;
   assign rsp_state_changed      = out_ff.changed;
   assign rsp_cmd_start_receiver = out_ff.start_rx;
   assign rsp_cmd_arm_receiver   = out_ff.arm_rx;
   assign rsp_note_fully_started = out_ff.fully_started;
   assign rsp_cmd_stop_receiver  = out_ff.stop_rx;
   assign rsp_note_fully_stopped = out_ff.fully_stopped;
   assign rsp_note_reconnect     = out_ff.reconnect;

endmodule

/* test/stream_session_lifecycle_fsm_top_tb.sv */
// ----------------------------------------------------------------------------
// stream_session_lifecycle_fsm_top_tb
// Self-checking bench for the streaming session lifecycle controller. Event
// words go in through a randomly idling sender. A behavioral copy of the state
// machine predicts every status word, and a checker compares each word taken
// from the status channel field by field. Registers change only between
// phases, once all status words have come back.
// ----------------------------------------------------------------------------
module stream_session_lifecycle_fsm_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sslf_pkg::*;

   localparam int TW = TIMER_WIDTH_DEF;

   // op codes above the last defined event; the block must ignore them
   localparam logic [OP_WIDTH-1:0]  OP_UNUSED_TOP   = 4'd15;
   // non-fatal error categories
   localparam logic [CAT_WIDTH-1:0] CAT_TRANSIENT   = 2'd0;
   localparam logic [CAT_WIDTH-1:0] CAT_NO_PLUGIN   = 2'd1;
   localparam logic [CAT_WIDTH-1:0] CAT_HW_FALLBACK = 2'd2;

   localparam int HOLD_CYCLES = 60;   // long receiver hold-off
   localparam int PHASE_ITEMS = 315;  // event words per random phase

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [OP_WIDTH-1:0]       req_op;
   logic [CAT_WIDTH-1:0]      req_error_category;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [2:0]                rsp_session_state;
   logic                      rsp_state_changed;
   logic                      rsp_cmd_start_receiver;
   logic                      rsp_cmd_arm_receiver;
   logic                      rsp_note_fully_started;
   logic                      rsp_cmd_stop_receiver;
   logic                      rsp_note_fully_stopped;
   logic                      rsp_note_reconnect;
   logic                      csr_wr_en;
   logic [CSR_IDX_WIDTH-1:0]  csr_index;
   logic [CSR_DATA_WIDTH-1:0] csr_data;

   // behavioral copy of the controller: registers and session state
   sslf_cfg_type              sess_cfg;
   sslf_state_type            sess_state;
   logic                      sess_started;   // starting was entered since idle
   logic [TW-1:0]             sess_dwell;     // ticks spent in starting/stopping

   sslf_result_type           status_due[$];  // predicted status words, oldest first
   int                        error_count = 0;
   int                        words_seen  = 0;

   // idle knobs shared with the receiver process
   bit                        req_idle_off  = 1'b0;
   bit                        rsp_idle_off  = 1'b0;
   bit                        long_hold_req = 1'b0;

   stream_session_lifecycle_fsm_top u_dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_op                 (req_op),
      .req_error_category     (req_error_category),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_session_state      (rsp_session_state),
      .rsp_state_changed      (rsp_state_changed),
      .rsp_cmd_start_receiver (rsp_cmd_start_receiver),
      .rsp_cmd_arm_receiver   (rsp_cmd_arm_receiver),
      .rsp_note_fully_started (rsp_note_fully_started),
      .rsp_cmd_stop_receiver  (rsp_cmd_stop_receiver),
      .rsp_note_fully_stopped (rsp_note_fully_stopped),
      .rsp_note_reconnect     (rsp_note_reconnect),
      .csr_wr_en              (csr_wr_en),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Transition table. dw is the dwell count after this event's tick, if any.
   function automatic sslf_state_type session_next(sslf_state_type st,
                                                   logic [TW-1:0] dw,
                                                   logic [OP_WIDTH-1:0] op,
                                                   logic [CAT_WIDTH-1:0] cat);
      logic           fatal;
      sslf_state_type fatal_to;
      fatal    = (op == OP_RX_ERROR) && (cat == CAT_FATAL);
      // soft reconnect: reconnecting stays put, every other active state but stopping goes there
      fatal_to = sess_cfg.allow_soft ? ST_RECONNECTING : ST_FAILED;
      case (st)
         ST_IDLE: begin
            if (op == OP_START) return ST_STARTING;
         end
         ST_STARTING: begin
            if (op == OP_RX_STARTED) return ST_CONNECTED;
            if (fatal) return fatal_to;
            if (op == OP_STOP) return ST_STOPPING;
            if (op == OP_TICK && dw >= sess_cfg.start_timeout) return ST_FAILED;
         end
         ST_CONNECTED: begin
            if (op == OP_FIRST_FRAME) return ST_STREAMING;
            if (op == OP_RX_PAUSED || op == OP_PAUSE) return ST_PAUSED;
            if (fatal) return fatal_to;
            if (op == OP_STOP) return ST_STOPPING;
         end
         ST_STREAMING: begin
            if (op == OP_RX_PAUSED || op == OP_PAUSE) return ST_PAUSED;
            if (fatal) return fatal_to;
            if (op == OP_STOP) return ST_STOPPING;
         end
         ST_PAUSED: begin
            if (op == OP_RX_RESUMED || op == OP_RESUME) return ST_STREAMING;
            if (fatal) return fatal_to;
            if (op == OP_STOP) return ST_STOPPING;
         end
         ST_RECONNECTING: begin
            if (op == OP_RX_STARTED) return ST_CONNECTED;
            if (fatal) return fatal_to;
            if (op == OP_STOP) return ST_STOPPING;
            if (op == OP_START) return ST_STARTING;
         end
         ST_STOPPING: begin
            if (op == OP_RX_STOPPED) return ST_IDLE;
            if (op == OP_TICK && dw >= sess_cfg.stop_timeout) return ST_IDLE;
         end
         default: ;  // failed: terminal
      endcase
      return st;
   endfunction

   // Apply one event to the session copy and return the status word it yields.
   function automatic sslf_result_type advance_session(logic [OP_WIDTH-1:0] op,
                                                       logic [CAT_WIDTH-1:0] cat);
      sslf_result_type r;
      sslf_state_type  nx;
      r = '0;
      // dwell counts only in starting/stopping and saturates
      if (op == OP_TICK && (sess_state == ST_STARTING || sess_state == ST_STOPPING)
          && sess_dwell != '1)
         sess_dwell++;
      nx = session_next(sess_state, sess_dwell, op, cat);
      if (nx != sess_state) begin
         sess_dwell = '0;
         r.changed  = 1'b1;
         case (nx)
            ST_IDLE: begin
               r.fully_stopped = sess_started & sess_cfg.rx_bound;
               sess_started    = 1'b0;
            end
            ST_STARTING: begin
               r.start_rx   = sess_cfg.rx_bound;
               sess_started = 1'b1;
            end
            ST_CONNECTED: begin
               r.arm_rx        = sess_cfg.rx_bound;
               r.fully_started = 1'b1;
            end
            ST_STOPPING:     r.stop_rx   = sess_cfg.rx_bound;
            ST_RECONNECTING: r.reconnect = 1'b1;
            default: ;
         endcase
         sess_state = nx;
      end
      r.state = sess_state;
      return r;
   endfunction

   function automatic void check_field(string name, logic [2:0] want, logic [2:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endfunction

   // Offer one event word; returns at the falling edge after it was taken.
   task automatic send_event(input logic [OP_WIDTH-1:0] op, input logic [CAT_WIDTH-1:0] cat);
      int gap;
      gap = req_idle_off ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid          <= 1'b1;
      req_op             <= op;
      req_error_category <= cat;
      do @(posedge clock); while (req_stall !== 1'b0);
      status_due.push_back(advance_session(op, cat));
      @(negedge clock);
   endtask

   // Mostly events that move the session along from where it is, some pure
   // noise. Never drives into failed unless already there: failed only ends
   // at reset, so it is kept for the last test.
   task automatic pick_event(output logic [OP_WIDTH-1:0] op,
                             output logic [CAT_WIDTH-1:0] cat);
      logic [OP_WIDTH-1:0] menu [4];
      logic [TW-1:0]       dw;
      int                  roll;
      do begin
         cat  = CAT_WIDTH'($urandom_range(0, 3));
         roll = $urandom_range(0, 99);
         if (roll < 55) begin
            case (sess_state)
               ST_STARTING:     menu = '{OP_RX_STARTED, OP_TICK, OP_STOP, OP_RX_ERROR};
               ST_CONNECTED:    menu = '{OP_FIRST_FRAME, OP_PAUSE, OP_RX_PAUSED, OP_RX_ERROR};
               ST_STREAMING:    menu = '{OP_PAUSE, OP_RX_PAUSED, OP_STOP, OP_RX_ERROR};
               ST_PAUSED:       menu = '{OP_RESUME, OP_RX_RESUMED, OP_STOP, OP_RX_ERROR};
               ST_RECONNECTING: menu = '{OP_RX_STARTED, OP_START, OP_STOP, OP_RX_ERROR};
               ST_STOPPING:     menu = '{OP_RX_STOPPED, OP_TICK, OP_TICK, OP_TICK};
               default:         menu = '{OP_START, OP_START, OP_START, OP_START};
            endcase
            op = menu[$urandom_range(0, 3)];
            if (op == OP_RX_ERROR) cat = CAT_FATAL;
         end else if (roll < 70) begin
            op = OP_TICK;
         end else if (roll < 96) begin
            op = OP_WIDTH'($urandom_range(OP_START, OP_RX_ERROR));
         end else begin
            op = OP_WIDTH'($urandom_range(OP_RX_ERROR + 1, OP_UNUSED_TOP));
         end
         dw = sess_dwell;
         if (op == OP_TICK && (sess_state == ST_STARTING || sess_state == ST_STOPPING)
             && dw != '1)
            dw++;
      end while (sess_state != ST_FAILED
                 && session_next(sess_state, dw, op, cat) == ST_FAILED);
   endtask

   task automatic send_random(int count);
      logic [OP_WIDTH-1:0]  op;
      logic [CAT_WIDTH-1:0] cat;
      repeat (count) begin
         pick_event(op, cat);
         send_event(op, cat);
      end
   endtask

   // Drop valid and wait for every predicted word; the block is idle after.
   task automatic wait_drained;
      req_valid <= 1'b0;
      while (status_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_WIDTH-1:0] idx, logic [CSR_DATA_WIDTH-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (idx)
         CSR_ALLOW_SOFT:    sess_cfg.allow_soft    = data[0];
         CSR_RX_BOUND:      sess_cfg.rx_bound      = data[0];
         CSR_START_TIMEOUT: sess_cfg.start_timeout = data;
         default:           sess_cfg.stop_timeout  = data;
      endcase
   endtask

   // Walk the whole lifecycle once by hand, then the ignored-event cases.
   task automatic test_directed;
      // reset defaults: unbound, soft reconnect on
      send_event(OP_TICK, CAT_TRANSIENT);        // tick in idle: counter untouched
      send_event(OP_UNUSED_TOP, CAT_FATAL);      // unused op code
      send_event(OP_RX_STOPPED, CAT_TRANSIENT);  // not valid in idle
      wait_drained;
      write_csr(CSR_RX_BOUND, 16'h0001);
      write_csr(CSR_STOP_TIMEOUT, 16'd2);
      send_event(OP_START, CAT_TRANSIENT);
      send_event(OP_TICK, CAT_TRANSIENT);
      send_event(OP_RX_ERROR, CAT_TRANSIENT);    // non-fatal errors change nothing
      send_event(OP_RX_ERROR, CAT_NO_PLUGIN);
      send_event(OP_RX_ERROR, CAT_HW_FALLBACK);
      send_event(OP_RX_STARTED, CAT_TRANSIENT);
      send_event(OP_FIRST_FRAME, CAT_TRANSIENT);
      send_event(OP_PAUSE, CAT_TRANSIENT);
      send_event(OP_RESUME, CAT_TRANSIENT);
      send_event(OP_RX_PAUSED, CAT_TRANSIENT);
      send_event(OP_RX_RESUMED, CAT_TRANSIENT);
      send_event(OP_RX_ERROR, CAT_FATAL);        // soft reconnect
      send_event(OP_RX_ERROR, CAT_FATAL);        // again while reconnecting: stays
      send_event(OP_START, CAT_TRANSIENT);
      send_event(OP_STOP, CAT_TRANSIENT);
      send_event(OP_TICK, CAT_TRANSIENT);
      send_event(OP_TICK, CAT_TRANSIENT);        // stop timeout -> idle, fully stopped
      wait_drained;
      write_csr(CSR_RX_BOUND, 16'hFFFE);         // unbound, upper bits ignored
      write_csr(CSR_STOP_TIMEOUT, 16'h0000);
      send_event(OP_START, CAT_TRANSIENT);
      send_event(OP_STOP, CAT_TRANSIENT);
      send_event(OP_TICK, CAT_TRANSIENT);        // zero timeout fires on first tick
      send_event(OP_START, CAT_TRANSIENT);
      send_event(OP_STOP, CAT_TRANSIENT);
      send_event(OP_RX_STOPPED, CAT_TRANSIENT);
   endtask

   // Receiver holds off for a long stretch while the sender keeps offering
   // back to back, so the pipe fills and req_stall rises. Then the sender
   // stops until every status word has come back.
   task automatic test_backpressure;
      wait_drained;
      req_idle_off  = 1'b1;
      long_hold_req = 1'b1;
      send_random(24);
      req_idle_off  = 1'b0;
      wait_drained;
   endtask

   // Random phases, each under its own register setting. Phase 0/1 hit the
   // timeout extremes, phase 4 runs with no idling on either side.
   task automatic test_random_traffic;
      logic [CSR_DATA_WIDTH-1:0] d;
      for (int p = 0; p < 6; p++) begin
         wait_drained;
         d    = CSR_DATA_WIDTH'($urandom);
         d[0] = (p % 3) != 2;
         write_csr(CSR_ALLOW_SOFT, d);
         d    = CSR_DATA_WIDTH'($urandom);
         d[0] = p[0];
         write_csr(CSR_RX_BOUND, d);
         case (p)
            0:       d = 16'hFFFF;
            1:       d = 16'h0000;
            3:       d = CSR_DATA_WIDTH'($urandom);
            default: d = CSR_DATA_WIDTH'($urandom_range(1, 40));
         endcase
         write_csr(CSR_START_TIMEOUT, d);
         case (p)
            0:       d = 16'h0000;
            1:       d = 16'hFFFF;
            default: d = CSR_DATA_WIDTH'($urandom_range(1, 24));
         endcase
         write_csr(CSR_STOP_TIMEOUT, d);
         req_idle_off = (p == 4);
         rsp_idle_off = (p == 4);
         send_random(PHASE_ITEMS);
      end
      req_idle_off = 1'b0;
      rsp_idle_off = 1'b0;
   endtask

   // Last: drive into failed (zero start timeout, short start timeout, or a
   // fatal error without soft reconnect) and check it ignores everything.
   task automatic test_terminal_failure;
      logic [OP_WIDTH-1:0]       op;
      logic [CSR_DATA_WIDTH-1:0] d;
      int                        variant;
      wait_drained;
      while (sess_state != ST_STARTING) begin
         case (sess_state)
            ST_IDLE, ST_RECONNECTING: op = OP_START;
            ST_STOPPING:              op = OP_RX_STOPPED;
            default:                  op = OP_STOP;
         endcase
         send_event(op, CAT_TRANSIENT);
      end
      wait_drained;
      variant = $urandom_range(0, 2);
      case (variant)
         0: write_csr(CSR_START_TIMEOUT, 16'h0000);
         1: write_csr(CSR_START_TIMEOUT, CSR_DATA_WIDTH'($urandom_range(1, 8)));
         default: begin
            d    = CSR_DATA_WIDTH'($urandom);
            d[0] = 1'b0;
            write_csr(CSR_ALLOW_SOFT, d);
         end
      endcase
      while (sess_state != ST_FAILED)
         send_event(variant == 2 ? OP_RX_ERROR : OP_TICK, CAT_FATAL);
      send_random(30);
   endtask

   // Receiver: a random stall before each word, or the long hold when asked.
   initial begin
      int hold_cycles;
      int stall_left;
      int seen;
      rsp_stall   = 1'b0;
      hold_cycles = 0;
      stall_left  = 0;
      seen        = 0;
      forever begin
         @(negedge clock);
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            hold_cycles   = HOLD_CYCLES;
         end
         if (words_seen != seen) begin
            seen       = words_seen;
            stall_left = rsp_idle_off ? 0 : $urandom_range(0, 7);
         end
         rsp_stall <= (hold_cycles > 0) || (stall_left > 0);
         if (hold_cycles > 0) hold_cycles--;
         if (stall_left > 0) stall_left--;
      end
   end

   // Status checker: every word taken is matched against the oldest prediction.
   always @(posedge clock) begin
      sslf_result_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         words_seen++;
         if (status_due.size() == 0) begin
            $error("status word with no event pending");
            error_count++;
         end else begin
            want = status_due.pop_front();
            check_field("session_state", want.state, rsp_session_state);
            check_field("state_changed", 3'(want.changed), 3'(rsp_state_changed));
            check_field("cmd_start_receiver", 3'(want.start_rx),
                        3'(rsp_cmd_start_receiver));
            check_field("cmd_arm_receiver", 3'(want.arm_rx), 3'(rsp_cmd_arm_receiver));
            check_field("note_fully_started", 3'(want.fully_started),
                        3'(rsp_note_fully_started));
            check_field("cmd_stop_receiver", 3'(want.stop_rx),
                        3'(rsp_cmd_stop_receiver));
            check_field("note_fully_stopped", 3'(want.fully_stopped),
                        3'(rsp_note_fully_stopped));
            check_field("note_reconnect", 3'(want.reconnect), 3'(rsp_note_reconnect));
         end
      end
   end

   // Watchdog: well past the slowest legal run.
   initial begin
      #(5_000_000);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      reset              = 1'b1;
      req_valid          = 1'b0;
      req_op             = OP_TICK;
      req_error_category = CAT_TRANSIENT;
      csr_wr_en          = 1'b0;
      csr_index          = CSR_ALLOW_SOFT;
      csr_data           = '0;
      sess_cfg           = {1'b1, 1'b0, START_TIMEOUT_RST, STOP_TIMEOUT_RST};
      sess_state         = ST_IDLE;
      sess_started       = 1'b0;
      sess_dwell         = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed;
      test_backpressure;
      test_random_traffic;
      test_terminal_failure;

      wait_drained;
      repeat (8) @(negedge clock);
      if (error_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
